// ----- sv/assert_macros.svh -----
// Assertion helpers for the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

// ----- sv/gbfs_pkg.sv -----
package gbfs_pkg;

  localparam int IDX_W  = 12;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 13;
  localparam int CFG_W  = 7;
  localparam int DIM_RESET = 64;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_SEARCH    = 2'd1,
    CMD_READ_KIND = 2'd2,
    CMD_READ_PATH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_EMPTY   = 2'd0,
    KIND_WALL    = 2'd1,
    KIND_VISITED = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STEP_ZERO,
    STEP_INC,
    STEP_DEC
  } step_t;

  // Neighbour order: down, up, right, left, then the four diagonals.
  localparam step_t STEP_DR [8] = '{STEP_INC, STEP_DEC, STEP_ZERO, STEP_ZERO,
                                    STEP_INC, STEP_INC, STEP_DEC, STEP_DEC};
  localparam step_t STEP_DC [8] = '{STEP_ZERO, STEP_ZERO, STEP_INC, STEP_DEC,
                                    STEP_INC, STEP_DEC, STEP_INC, STEP_DEC};

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_RESULT, ST_INIT, ST_CLEAR, ST_SEED, ST_DEQ,
    ST_CUR, ST_NB, ST_A1, ST_A2, ST_A3, ST_NX, ST_TAKE, ST_DIR, ST_FIN_RD,
    ST_FIN_CHK, ST_CNT, ST_CNT_LD, ST_FILL, ST_FILL_LD
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_WRITE_KIND, OP_READ_KIND, OP_READ_PATH, OP_INIT,
    OP_CLEAR, OP_SEED, OP_DEQ, OP_LOAD_CUR, OP_NB, OP_RD_A1, OP_RD_A2,
    OP_RD_NX, OP_TAKE, OP_DIR_INC, OP_RD_FIN, OP_WALK_INIT, OP_CNT_RD,
    OP_WALK_LOAD, OP_FILL_INIT, OP_FILL, OP_RESULT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t lat_cmd;
    logic clr_last;
    logic range_bad;
    logic q_empty;
    logic cur_fin;
    logic nb_ok;
    logic nb_diag;
    logic diag_blocked;
    logic take;
    logic dir_last;
    logic fin_reached;
    logic walk_start;
    logic pos_one;
    logic out_blocked;
  } dp_status_t;

endpackage

// ----- sv/gbfs_ctrl.sv -----
module gbfs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  gbfs_pkg::dp_status_t  st,
  output gbfs_pkg::dp_cmd_t     dpc
);

  gbfs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = (state != gbfs_pkg::ST_IDLE) || st.out_blocked;

  always_comb begin
    state_next = state;
    dpc.op = gbfs_pkg::OP_NONE;
    unique case (state)
      gbfs_pkg::ST_IDLE: begin
        if (cmd_valid && !cmd_stall) begin
          dpc.op = gbfs_pkg::OP_LATCH;
          state_next = gbfs_pkg::ST_DISPATCH;
        end
      end
      gbfs_pkg::ST_DISPATCH: begin
        unique case (st.lat_cmd)
          gbfs_pkg::CMD_WRITE: begin
            dpc.op = gbfs_pkg::OP_WRITE_KIND;
            state_next = gbfs_pkg::ST_RESULT;
          end
          gbfs_pkg::CMD_SEARCH: begin
            state_next = gbfs_pkg::ST_INIT;
          end
          gbfs_pkg::CMD_READ_KIND: begin
            dpc.op = gbfs_pkg::OP_READ_KIND;
            state_next = gbfs_pkg::ST_RESULT;
          end
          default: begin
            dpc.op = gbfs_pkg::OP_READ_PATH;
            state_next = gbfs_pkg::ST_RESULT;
          end
        endcase
      end
      gbfs_pkg::ST_RESULT: begin
        dpc.op = gbfs_pkg::OP_RESULT;
        state_next = gbfs_pkg::ST_IDLE;
      end
      gbfs_pkg::ST_INIT: begin
        dpc.op = gbfs_pkg::OP_INIT;
        state_next = gbfs_pkg::ST_CLEAR;
      end
      gbfs_pkg::ST_CLEAR: begin
        dpc.op = gbfs_pkg::OP_CLEAR;
        if (st.clr_last) begin
          state_next = gbfs_pkg::ST_SEED;
        end
      end
      gbfs_pkg::ST_SEED: begin
        if (st.range_bad) begin
          state_next = gbfs_pkg::ST_RESULT;
        end else begin
          dpc.op = gbfs_pkg::OP_SEED;
          state_next = gbfs_pkg::ST_DEQ;
        end
      end
      gbfs_pkg::ST_DEQ: begin
        if (st.q_empty) begin
          state_next = gbfs_pkg::ST_FIN_RD;
        end else begin
          dpc.op = gbfs_pkg::OP_DEQ;
          state_next = gbfs_pkg::ST_CUR;
        end
      end
      gbfs_pkg::ST_CUR: begin
        dpc.op = gbfs_pkg::OP_LOAD_CUR;
        state_next = gbfs_pkg::ST_NB;
      end
      gbfs_pkg::ST_NB: begin
        priority if (st.cur_fin) begin
          state_next = gbfs_pkg::ST_FIN_RD;
        end else if (!st.nb_ok) begin
          state_next = gbfs_pkg::ST_DIR;
        end else begin
          dpc.op = gbfs_pkg::OP_NB;
          state_next = st.nb_diag ? gbfs_pkg::ST_A1 : gbfs_pkg::ST_NX;
        end
      end
      gbfs_pkg::ST_A1: begin
        dpc.op = gbfs_pkg::OP_RD_A1;
        state_next = gbfs_pkg::ST_A2;
      end
      gbfs_pkg::ST_A2: begin
        dpc.op = gbfs_pkg::OP_RD_A2;
        state_next = gbfs_pkg::ST_A3;
      end
      gbfs_pkg::ST_A3: begin
        state_next = st.diag_blocked ? gbfs_pkg::ST_DIR : gbfs_pkg::ST_NX;
      end
      gbfs_pkg::ST_NX: begin
        dpc.op = gbfs_pkg::OP_RD_NX;
        state_next = gbfs_pkg::ST_TAKE;
      end
      gbfs_pkg::ST_TAKE: begin
        if (st.take) begin
          dpc.op = gbfs_pkg::OP_TAKE;
        end
        state_next = gbfs_pkg::ST_DIR;
      end
      gbfs_pkg::ST_DIR: begin
        if (st.dir_last) begin
          state_next = gbfs_pkg::ST_DEQ;
        end else begin
          dpc.op = gbfs_pkg::OP_DIR_INC;
          state_next = gbfs_pkg::ST_NB;
        end
      end
      gbfs_pkg::ST_FIN_RD: begin
        dpc.op = gbfs_pkg::OP_RD_FIN;
        state_next = gbfs_pkg::ST_FIN_CHK;
      end
      gbfs_pkg::ST_FIN_CHK: begin
        if (st.fin_reached) begin
          dpc.op = gbfs_pkg::OP_WALK_INIT;
          state_next = gbfs_pkg::ST_CNT;
        end else begin
          state_next = gbfs_pkg::ST_RESULT;
        end
      end
      gbfs_pkg::ST_CNT: begin
        if (st.walk_start) begin
          dpc.op = gbfs_pkg::OP_FILL_INIT;
          state_next = gbfs_pkg::ST_FILL;
        end else begin
          dpc.op = gbfs_pkg::OP_CNT_RD;
          state_next = gbfs_pkg::ST_CNT_LD;
        end
      end
      gbfs_pkg::ST_CNT_LD: begin
        dpc.op = gbfs_pkg::OP_WALK_LOAD;
        state_next = gbfs_pkg::ST_CNT;
      end
      gbfs_pkg::ST_FILL: begin
        dpc.op = gbfs_pkg::OP_FILL;
        state_next = st.pos_one ? gbfs_pkg::ST_RESULT : gbfs_pkg::ST_FILL_LD;
      end
      gbfs_pkg::ST_FILL_LD: begin
        dpc.op = gbfs_pkg::OP_WALK_LOAD;
        state_next = gbfs_pkg::ST_FILL;
      end
      default: begin
        state_next = gbfs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/gbfs_dp.sv -----
module gbfs_dp #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [gbfs_pkg::CFG_W-1:0]       cfg_data,
  input  logic [1:0]                       cmd,
  input  logic [gbfs_pkg::IDX_W-1:0]       cell_index,
  input  logic [gbfs_pkg::KIND_W-1:0]      cell_kind,
  input  logic [gbfs_pkg::IDX_W-1:0]       start_cell,
  input  logic [gbfs_pkg::IDX_W-1:0]       finish_cell,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [gbfs_pkg::KIND_W-1:0]      cell_kind_out,
  output logic                             path_found,
  output logic [gbfs_pkg::LEN_W-1:0]       path_length,
  output logic [gbfs_pkg::IDX_W-1:0]       path_cell,
  input  gbfs_pkg::dp_cmd_t                dpc,
  output gbfs_pkg::dp_status_t             st
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW    = AW + 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RDW   = $clog2(MAX_ROWS + 1);
  localparam int CDW   = $clog2(MAX_COLS + 1);
  localparam int UW    = $clog2(CELLS + 1);
  localparam int QW    = AW + RW + CW;
  localparam int LW    = gbfs_pkg::LEN_W;

  logic [gbfs_pkg::CFG_W-1:0] rows_cfg, cols_cfg;
  logic [RDW-1:0] rows;
  logic [CDW-1:0] cols;

  gbfs_pkg::cmd_t lat_cmd;
  logic [gbfs_pkg::IDX_W-1:0] lat_idx, lat_start, lat_finish;
  gbfs_pkg::kind_t lat_kind;

  logic [UW-1:0] used;
  logic [AW-1:0] clr;
  logic [RW-1:0] clr_r, start_r, cur_r, nr, nr_c;
  logic [CW-1:0] clr_c, start_c, cur_c, nc, nc_c;
  logic [PW-1:0] head, tail;
  logic [AW-1:0] cur_idx, next_idx, walk;
  logic [2:0] dir;
  logic wall1;
  logic [LW-1:0] n, pos, found_len;

  logic [gbfs_pkg::KIND_W-1:0] kinds [CELLS];
  logic visited [CELLS];
  logic [AW-1:0] parents [CELLS];
  logic [QW-1:0] queue [CELLS];
  logic [AW-1:0] paths [CELLS];

  logic [gbfs_pkg::KIND_W-1:0] kq;
  logic vq;
  logic [AW-1:0] pq, sq;
  logic [QW-1:0] qq;

  logic [AW-1:0] ia, a1, a2, nx_addr, k_raddr, v_raddr;
  logic idx_ok, ok_r, ok_c;
  gbfs_pkg::step_t dr, dc;

  always_comb begin
    if (rows_cfg == '0) begin
      rows = RDW'(1);
    end else if (32'(rows_cfg) > MAX_ROWS) begin
      rows = RDW'(MAX_ROWS);
    end else begin
      rows = RDW'(rows_cfg);
    end
    if (cols_cfg == '0) begin
      cols = CDW'(1);
    end else if (32'(cols_cfg) > MAX_COLS) begin
      cols = CDW'(MAX_COLS);
    end else begin
      cols = CDW'(cols_cfg);
    end
  end

  assign idx_ok  = 32'(lat_idx) < CELLS;
  assign ia      = AW'(lat_idx);
  assign a1      = AW'(AW'(cur_r) * AW'(cols) + AW'(nc));
  assign a2      = AW'(AW'(nr) * AW'(cols) + AW'(cur_c));
  assign nx_addr = AW'(AW'(nr) * AW'(cols) + AW'(nc));
  assign dr      = gbfs_pkg::STEP_DR[dir];
  assign dc      = gbfs_pkg::STEP_DC[dir];

  always_comb begin
    unique case (dr)
      gbfs_pkg::STEP_INC: begin
        nr_c = cur_r + RW'(1);
        ok_r = (32'(cur_r) + 1) < 32'(rows);
      end
      gbfs_pkg::STEP_DEC: begin
        nr_c = cur_r - RW'(1);
        ok_r = cur_r != '0;
      end
      default: begin
        nr_c = cur_r;
        ok_r = 1'b1;
      end
    endcase
    unique case (dc)
      gbfs_pkg::STEP_INC: begin
        nc_c = cur_c + CW'(1);
        ok_c = (32'(cur_c) + 1) < 32'(cols);
      end
      gbfs_pkg::STEP_DEC: begin
        nc_c = cur_c - CW'(1);
        ok_c = cur_c != '0;
      end
      default: begin
        nc_c = cur_c;
        ok_c = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (dpc.op)
      gbfs_pkg::OP_READ_KIND: k_raddr = ia;
      gbfs_pkg::OP_RD_A1:     k_raddr = a1;
      gbfs_pkg::OP_RD_A2:     k_raddr = a2;
      default:                k_raddr = nx_addr;
    endcase
    v_raddr = (dpc.op == gbfs_pkg::OP_RD_FIN) ? AW'(lat_finish) : nx_addr;
  end

  // Memories, each with one write port and a registered read.
  always_ff @(posedge clk) begin
    if (dpc.op == gbfs_pkg::OP_WRITE_KIND && idx_ok) begin
      kinds[ia] <= lat_kind;
    end else if (dpc.op == gbfs_pkg::OP_TAKE && kq == gbfs_pkg::KIND_EMPTY) begin
      kinds[next_idx] <= gbfs_pkg::KIND_VISITED;
    end
    kq <= kinds[k_raddr];
  end

  always_ff @(posedge clk) begin
    unique case (dpc.op)
      gbfs_pkg::OP_CLEAR: visited[clr] <= 1'b0;
      gbfs_pkg::OP_SEED:  visited[AW'(lat_start)] <= 1'b1;
      gbfs_pkg::OP_TAKE:  visited[next_idx] <= 1'b1;
      default: begin
      end
    endcase
    vq <= visited[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (dpc.op == gbfs_pkg::OP_TAKE) begin
      parents[next_idx] <= cur_idx;
    end
    pq <= parents[walk];
  end

  always_ff @(posedge clk) begin
    if (dpc.op == gbfs_pkg::OP_SEED) begin
      queue[0] <= {AW'(lat_start), start_r, start_c};
    end else if (dpc.op == gbfs_pkg::OP_TAKE) begin
      queue[tail[AW-1:0]] <= {next_idx, nr, nc};
    end
    qq <= queue[head[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dpc.op == gbfs_pkg::OP_FILL) begin
      paths[AW'(pos - LW'(1))] <= walk;
    end
    sq <= paths[ia];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg     <= gbfs_pkg::CFG_W'(gbfs_pkg::DIM_RESET);
      cols_cfg     <= gbfs_pkg::CFG_W'(gbfs_pkg::DIM_RESET);
      found_len    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gbfs_pkg::CFG_ROWS) begin
          rows_cfg <= cfg_data;
        end else begin
          cols_cfg <= cfg_data;
        end
      end
      if (dpc.op == gbfs_pkg::OP_INIT) begin
        found_len <= '0;
      end else if (dpc.op == gbfs_pkg::OP_FILL && pos == LW'(1)) begin
        found_len <= n;
      end
      if (dpc.op == gbfs_pkg::OP_RESULT) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (dpc.op)
      gbfs_pkg::OP_LATCH: begin
        lat_cmd    <= gbfs_pkg::cmd_t'(cmd);
        lat_idx    <= cell_index;
        lat_kind   <= gbfs_pkg::kind_t'(cell_kind);
        lat_start  <= start_cell;
        lat_finish <= finish_cell;
      end
      gbfs_pkg::OP_INIT: begin
        used  <= UW'(UW'(rows) * UW'(cols));
        clr   <= '0;
        clr_r <= '0;
        clr_c <= '0;
      end
      gbfs_pkg::OP_CLEAR: begin
        if (32'(clr) == 32'(lat_start)) begin
          start_r <= clr_r;
          start_c <= clr_c;
        end
        clr <= clr + AW'(1);
        if ((32'(clr_c) + 1) == 32'(cols)) begin
          clr_c <= '0;
          clr_r <= clr_r + RW'(1);
        end else begin
          clr_c <= clr_c + CW'(1);
        end
      end
      gbfs_pkg::OP_SEED: begin
        head <= '0;
        tail <= PW'(1);
      end
      gbfs_pkg::OP_DEQ: begin
        head <= head + PW'(1);
      end
      gbfs_pkg::OP_LOAD_CUR: begin
        {cur_idx, cur_r, cur_c} <= qq;
        dir <= '0;
      end
      gbfs_pkg::OP_NB: begin
        nr <= nr_c;
        nc <= nc_c;
      end
      gbfs_pkg::OP_RD_A2: begin
        wall1 <= kq == gbfs_pkg::KIND_WALL;
      end
      gbfs_pkg::OP_RD_NX: begin
        next_idx <= nx_addr;
      end
      gbfs_pkg::OP_TAKE: begin
        tail <= tail + PW'(1);
      end
      gbfs_pkg::OP_DIR_INC: begin
        dir <= dir + 3'd1;
      end
      gbfs_pkg::OP_WALK_INIT: begin
        walk <= AW'(lat_finish);
        n    <= LW'(1);
      end
      gbfs_pkg::OP_CNT_RD: begin
        n <= n + LW'(1);
      end
      gbfs_pkg::OP_WALK_LOAD: begin
        walk <= pq;
      end
      gbfs_pkg::OP_FILL_INIT: begin
        walk <= AW'(lat_finish);
        pos  <= n;
      end
      gbfs_pkg::OP_FILL: begin
        pos <= pos - LW'(1);
      end
      gbfs_pkg::OP_RESULT: begin
        cell_kind_out <= (lat_cmd == gbfs_pkg::CMD_READ_KIND && idx_ok)
                         ? kq : gbfs_pkg::KIND_EMPTY;
        path_cell <= (lat_cmd == gbfs_pkg::CMD_READ_PATH && idx_ok
                      && 32'(lat_idx) < 32'(found_len))
                     ? gbfs_pkg::IDX_W'(sq) : '0;
      end
      default: begin
      end
    endcase
  end

  assign path_found  = found_len != '0;
  assign path_length = found_len;

  assign st.lat_cmd      = lat_cmd;
  assign st.clr_last     = clr == AW'(CELLS - 1);
  assign st.range_bad    = (32'(lat_start) >= 32'(used)) || (32'(lat_finish) >= 32'(used));
  assign st.q_empty      = head == tail;
  assign st.cur_fin      = 32'(cur_idx) == 32'(lat_finish);
  assign st.nb_ok        = ok_r && ok_c;
  assign st.nb_diag      = (dr != gbfs_pkg::STEP_ZERO) && (dc != gbfs_pkg::STEP_ZERO);
  assign st.diag_blocked = wall1 || (kq == gbfs_pkg::KIND_WALL);
  assign st.take         = !vq && (kq != gbfs_pkg::KIND_WALL) && (32'(tail) < CELLS);
  assign st.dir_last     = dir == 3'd7;
  assign st.fin_reached  = vq && (lat_start != lat_finish);
  assign st.walk_start   = 32'(walk) == 32'(lat_start);
  assign st.pos_one      = pos == LW'(1);
  assign st.out_blocked  = result_valid && result_stall;

endmodule

// ----- sv/grid_bfs_shortest_path.sv -----
// Channel   Handshake                  Word
// command   cmd_valid / cmd_stall      cmd, cell_index, cell_kind, start_cell, finish_cell
// result    result_valid / result_stall  cell_kind_out, path_found, path_length, path_cell
// config    cfg_we                     cfg_index, cfg_data
//
// A cell write or read passes the dispatch and result states before its result word
// is registered. A search clears the whole visited map, then checks the eight neighbours
// of each dequeued cell, reading both side cells of a diagonal step first, then walks the
// parent links twice over, once to count the path and once to store it.
// Reset is synchronous; the cell kind and path stores are not cleared.
// A new command is taken once the previous word has left the result register.
`include "assert_macros.svh"

module grid_bfs_shortest_path #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [gbfs_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [1:0]                   cmd,
  input  logic [gbfs_pkg::IDX_W-1:0]   cell_index,
  input  logic [gbfs_pkg::KIND_W-1:0]  cell_kind,
  input  logic [gbfs_pkg::IDX_W-1:0]   start_cell,
  input  logic [gbfs_pkg::IDX_W-1:0]   finish_cell,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [gbfs_pkg::KIND_W-1:0]  cell_kind_out,
  output logic                         path_found,
  output logic [gbfs_pkg::LEN_W-1:0]   path_length,
  output logic [gbfs_pkg::IDX_W-1:0]   path_cell
);

  gbfs_pkg::dp_cmd_t    dpc;
  gbfs_pkg::dp_status_t st;

  gbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .st        (st),
    .dpc       (dpc)
  );

  gbfs_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .cell_index    (cell_index),
    .cell_kind     (cell_kind),
    .start_cell    (start_cell),
    .finish_cell   (finish_cell),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .cell_kind_out (cell_kind_out),
    .path_found    (path_found),
    .path_length   (path_length),
    .path_cell     (path_cell),
    .dpc           (dpc),
    .st            (st)
  );

  `ASSERT_CLK(a_busy_after_accept, (cmd_valid && !cmd_stall) |=> cmd_stall)
  `ASSERT_CLK(a_found_matches_len, result_valid |-> (path_found == (path_length != '0)))
  `ASSERT_CLK(a_result_held, (result_valid && result_stall) |=> (result_valid && $stable(path_cell)))

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

  typedef struct packed {
    logic [gbfs_pkg::KIND_W-1:0] kind;
    logic                        found;
    logic [gbfs_pkg::LEN_W-1:0]  len;
    logic [gbfs_pkg::IDX_W-1:0]  pcell;
  } path_word_t;

  class path_scoreboard;
    logic [1:0]  kinds [4096];
    logic [11:0] path_mem [4096];
    bit          seen [4096];
    bit          has_parent [4096];
    int          parent [4096];
    int          frontier [4096];
    int          found_len;
    int          rows_reg;
    int          cols_reg;
    int          errors;
    path_word_t  pending [$];

    function new();
      rows_reg = gbfs_pkg::DIM_RESET;
      cols_reg = gbfs_pkg::DIM_RESET;
      found_len = 0;
      errors = 0;
      foreach (kinds[i]) begin
        kinds[i] = gbfs_pkg::KIND_EMPTY;
        path_mem[i] = '0;
      end
    endfunction

    function void set_reg(logic idx, int v);
      if (idx == gbfs_pkg::CFG_ROWS) rows_reg = v;
      else cols_reg = v;
    endfunction

    function int clamp(int v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
    endfunction

    function void search(int s, int f);
      int rows, cols, used, head, tail, cur, r, c, nr, nc, nxt, a1, a2, n, pos;
      int dr [8];
      int dc [8];
      dr = '{1, -1, 0, 0, 1, 1, -1, -1};
      dc = '{0, 0, 1, -1, 1, -1, 1, -1};
      rows = clamp(rows_reg);
      cols = clamp(cols_reg);
      used = rows * cols;
      head = 0;
      tail = 0;
      found_len = 0;
      foreach (seen[i]) begin
        seen[i] = 0;
        has_parent[i] = 0;
      end
      if (s >= used || f >= used) return;
      frontier[tail++] = s;
      seen[s] = 1;
      while (head < tail) begin
        cur = frontier[head++];
        if (cur == f) break;
        r = cur / cols;
        c = cur % cols;
        for (int d = 0; d < 8; d++) begin
          nr = r + dr[d];
          nc = c + dc[d];
          if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
          nxt = nr * cols + nc;
          if (dr[d] != 0 && dc[d] != 0) begin
            a1 = r * cols + nc;
            a2 = nr * cols + c;
            if (kinds[a1] == gbfs_pkg::KIND_WALL || kinds[a2] == gbfs_pkg::KIND_WALL)
              continue;
          end
          if (!seen[nxt] && kinds[nxt] != gbfs_pkg::KIND_WALL && tail < 4096) begin
            seen[nxt] = 1;
            parent[nxt] = cur;
            has_parent[nxt] = 1;
            frontier[tail++] = nxt;
            if (kinds[nxt] == gbfs_pkg::KIND_EMPTY) kinds[nxt] = gbfs_pkg::KIND_VISITED;
          end
        end
      end
      if (!has_parent[f]) return;
      n = 0;
      cur = f;
      while (n < 4096) begin
        n++;
        if (cur == s || !has_parent[cur]) break;
        cur = parent[cur];
      end
      cur = f;
      for (pos = n; pos > 0; pos--) begin
        path_mem[pos-1] = 12'(cur);
        if (has_parent[cur]) cur = parent[cur];
      end
      found_len = n;
    endfunction

    function void note(gbfs_pkg::cmd_t c, int idx, int k, int s, int f);
      path_word_t w;
      w = '0;
      idx = idx & 'hFFF;
      k = k & 'h3;
      s = s & 'hFFF;
      f = f & 'hFFF;
      case (c)
        gbfs_pkg::CMD_WRITE: kinds[idx] = 2'(k);
        gbfs_pkg::CMD_SEARCH: search(s, f);
        gbfs_pkg::CMD_READ_KIND: w.kind = kinds[idx];
        default: if (idx < found_len) w.pcell = path_mem[idx];
      endcase
      w.found = (found_len != 0);
      w.len = 13'(found_len);
      pending = {pending, w};
    endfunction

    function void check(path_word_t got);
      path_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind) begin
        $error("cell_kind_out expected %0d actual %0d", e.kind, got.kind);
        errors++;
      end
      if (got.found !== e.found) begin
        $error("path_found expected %0d actual %0d", e.found, got.found);
        errors++;
      end
      if (got.len !== e.len) begin
        $error("path_length expected %0d actual %0d", e.len, got.len);
        errors++;
      end
      if (got.pcell !== e.pcell) begin
        $error("path_cell expected %0d actual %0d", e.pcell, got.pcell);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [gbfs_pkg::CFG_W-1:0] cfg_data = '0;
  logic cmd_valid = 0;
  logic cmd_stall;
  logic [1:0] cmd = '0;
  logic [gbfs_pkg::IDX_W-1:0] cell_index = '0;
  logic [gbfs_pkg::KIND_W-1:0] cell_kind = '0;
  logic [gbfs_pkg::IDX_W-1:0] start_cell = '0;
  logic [gbfs_pkg::IDX_W-1:0] finish_cell = '0;
  logic result_valid;
  logic result_stall = 0;
  logic [gbfs_pkg::KIND_W-1:0] cell_kind_out;
  logic path_found;
  logic [gbfs_pkg::LEN_W-1:0] path_length;
  logic [gbfs_pkg::IDX_W-1:0] path_cell;

  path_scoreboard sb = new();
  int send_idle = 32;
  int recv_idle = 66;
  int item_count = 0;
  longint cycles = 0;

  grid_bfs_shortest_path dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_idle);
    if (!rst && result_valid && !result_stall)
      sb.check({cell_kind_out, path_found, path_length, path_cell});
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("[grid_bfs_shortest_path] ERROR");
      $finish;
    end
  end

  task automatic send(gbfs_pkg::cmd_t c, int idx, int k, int s, int f);
    if (item_count >= 67) begin
      send_idle = 0;
      recv_idle = 0;
    end else if (item_count >= 33) begin
      send_idle = 66;
      recv_idle = 32;
    end
    while ($urandom_range(0, 99) < send_idle) begin
      cmd_valid <= 0;
      @(posedge clk);
    end
    cmd <= c;
    cell_index <= 12'(idx);
    cell_kind <= 2'(k);
    start_cell <= 12'(s);
    finish_cell <= 12'(f);
    cmd_valid <= 1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note(c, idx, k, s, f);
    item_count++;
  endtask

  task automatic drain();
    cmd_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_dims(int r, int c);
    drain();
    cfg_we <= 1;
    cfg_index <= gbfs_pkg::CFG_ROWS;
    cfg_data <= 7'(r);
    @(posedge clk);
    sb.set_reg(gbfs_pkg::CFG_ROWS, r);
    cfg_index <= gbfs_pkg::CFG_COLS;
    cfg_data <= 7'(c);
    @(posedge clk);
    sb.set_reg(gbfs_pkg::CFG_COLS, c);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic grid_sequence();
    int used, s, f, len;
    used = sb.clamp(sb.rows_reg) * sb.clamp(sb.cols_reg);
    repeat ($urandom_range(0, 3))
      send(gbfs_pkg::CMD_WRITE, $urandom_range(0, used - 1), $urandom_range(0, 3),
           $urandom, $urandom);
    s = $urandom_range(0, used - 1);
    f = $urandom_range(0, used - 1);
    case ($urandom_range(0, 9))
      0: f = s;
      1: s = $urandom_range(0, 4095);
      2: f = $urandom_range(0, 4095);
      default: ;
    endcase
    send(gbfs_pkg::CMD_SEARCH, $urandom, $urandom, s, f);
    len = sb.found_len;
    for (int p = 0; p <= len && p < 5; p++)
      send(gbfs_pkg::CMD_READ_PATH, p, $urandom, $urandom, $urandom);
    if (len > 0) send(gbfs_pkg::CMD_READ_PATH, len - 1, $urandom, $urandom, $urandom);
    send(gbfs_pkg::CMD_READ_KIND, $urandom_range(0, 63), $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Only the first 64 cells are used, so the grid in use never exceeds them.
    set_dims(8, 8);
    for (int i = 0; i < 64; i++)
      send(gbfs_pkg::CMD_WRITE, i,
           ($urandom_range(0, 3) == 0) ? gbfs_pkg::KIND_WALL : $urandom_range(0, 3),
           $urandom, $urandom);

    send(gbfs_pkg::CMD_WRITE, 0, gbfs_pkg::KIND_EMPTY, 0, 0);
    send(gbfs_pkg::CMD_WRITE, 63, gbfs_pkg::KIND_OTHER, 63, 63);
    send(gbfs_pkg::CMD_READ_KIND, 0, 0, 0, 0);
    send(gbfs_pkg::CMD_READ_KIND, 63, 0, 0, 0);
    send(gbfs_pkg::CMD_SEARCH, 0, 0, 0, 63);
    send(gbfs_pkg::CMD_READ_PATH, 0, 0, 0, 0);
    send(gbfs_pkg::CMD_READ_PATH, sb.found_len > 0 ? sb.found_len - 1 : 0, 0, 0, 0);
    send(gbfs_pkg::CMD_READ_PATH, 4095, 0, 0, 0);
    send(gbfs_pkg::CMD_SEARCH, 0, 0, 5, 5);
    send(gbfs_pkg::CMD_SEARCH, 0, 0, 77, 3);
    send(gbfs_pkg::CMD_WRITE, 10, gbfs_pkg::KIND_WALL, 0, 0);
    send(gbfs_pkg::CMD_SEARCH, 0, 0, 0, 10);
    send(gbfs_pkg::CMD_WRITE, 63, gbfs_pkg::KIND_WALL, 0, 0);
    send(gbfs_pkg::CMD_WRITE, 62, gbfs_pkg::KIND_EMPTY, 0, 0);
    send(gbfs_pkg::CMD_SEARCH, 0, 0, 63, 62);
    send(gbfs_pkg::CMD_READ_PATH, 1, 0, 0, 0);
    send(gbfs_pkg::CMD_READ_KIND, 62, 0, 0, 0);
    set_dims(0, 0);
    send(gbfs_pkg::CMD_SEARCH, 0, 0, 0, 1);
    set_dims(127, 1);
    send(gbfs_pkg::CMD_SEARCH, 0, 0, 0, 63);
    send(gbfs_pkg::CMD_READ_PATH, 5, 0, 0, 0);

    while (item_count < 100) begin
      case ($urandom_range(0, 5))
        0: set_dims(127, $urandom_range(0, 1));
        1: set_dims($urandom_range(0, 1), 127);
        default: set_dims($urandom_range(0, 8), $urandom_range(0, 8));
      endcase
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 4) == 0)
          send(gbfs_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 63),
               $urandom, $urandom, $urandom);
        else
          grid_sequence();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[grid_bfs_shortest_path] OK");
    else
      $display("[grid_bfs_shortest_path] ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/gbfs_pkg.sv
sv/gbfs_ctrl.sv
sv/gbfs_dp.sv
sv/grid_bfs_shortest_path.sv
tb/tb_top.sv
